// ===== rtl/core/mhpq_pkg.sv =====
// Shared types and constants for the binary max-heap priority queue.
// No dependencies; imported by the top level of the queue and by its testbench.
package mhpq_pkg;

    // Default number of heap slots.
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Field widths fixed by the interface.
    localparam int unsigned ID_W   = 16;
    localparam int unsigned KEY_W  = 16;
    localparam int unsigned FILL_W = 5;
    localparam int unsigned STAT_W = 2;

    // Command codes carried on the input tuser.
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // One heap slot: record id and its priority key.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } entry_t;

endpackage

// ===== rtl/core/mhpq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mhpq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the read data is registered and valid in the cycle after the read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/max_heap_priority_queue_top.sv =====
// Top level of the binary max-heap priority queue: sequencer, count and result register.
// Depends on mhpq_pkg and the heap storage RAM mhpq_ram.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tuser[0] command; tdata[15:0] book_id, tdata[31:16] page_count
//  m_axis    out  tuser[1:0] status; tdata[15:0] out_id, [31:16] out_pages,
//                 [36:32] fill_level, [39:37] zero
//
// An insert moves up a level per read of the parent and compare; an extract captures the root,
// fetches the last entry and moves down a level per left fetch, right fetch and compare; a
// dropped insert or an empty extract goes straight to the result. The single read port of the
// heap RAM, one slot per cycle, and one shared key comparator set this pacing. The input is
// ready again in the cycle after the result loads, so a new beat is taken only once the last
// one is finished.
// Reset clears the entry count and the sequencer; the heap RAM is not cleared.
// The input is ready only while the sequencer is idle; a finished result waits in ST_DONE
// until the output register is free or being emptied, and only then loads into it.
module max_heap_priority_queue_top
    import mhpq_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] book_id, [31:16] page_count
    input  logic [0:0]  s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] out_id, [31:16] out_pages, [36:32] fill_level
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CHD_W = IDX_W + 2;

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UP_RD   = 4'd1;
    localparam logic [3:0] ST_UP_CMP  = 4'd2;
    localparam logic [3:0] ST_EX_ROOT = 4'd3;
    localparam logic [3:0] ST_EX_LAST = 4'd4;
    localparam logic [3:0] ST_DN_L    = 4'd5;
    localparam logic [3:0] ST_DN_R    = 4'd6;
    localparam logic [3:0] ST_DN_C    = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    logic [3:0]        state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [IDX_W-1:0]  pos_reg,       pos_next;
    entry_t            elem_reg,      elem_next;
    entry_t            best_reg,      best_next;
    logic              best_sel_reg,  best_sel_next;
    logic              rv_reg,        rv_next;
    logic [STAT_W-1:0] status_reg,    status_next;
    entry_t            res_reg,       res_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg;
    entry_t            out_entry_reg;
    logic [FILL_W-1:0] out_fill_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    entry_t            ram_rdata;

    logic              in_beat;
    logic              out_load;
    entry_t            in_entry;
    logic [CHD_W-1:0]  left_idx;
    logic [CHD_W-1:0]  right_idx;
    logic [CHD_W-1:0]  count_ext;
    logic [IDX_W-1:0]  parent_idx;
    logic [KEY_W-1:0]  cmp_a;
    logic [KEY_W-1:0]  cmp_b;
    logic              key_gt;
    logic              take_right;

    // Heap storage.
    mhpq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and index arithmetic.
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign in_entry.id   = s_axis_tdata[15:0];
    assign in_entry.key  = s_axis_tdata[31:16];
    assign left_idx      = {1'b0, pos_reg, 1'b1};
    assign right_idx     = left_idx + CHD_W'(1);
    assign count_ext     = CHD_W'(count_reg);
    assign parent_idx    = (pos_reg - IDX_W'(1)) >> 1;

    // One key comparator shared by the sift-up and sift-down steps.
    assign cmp_a      = (state_reg == ST_UP_CMP) ? elem_reg.key : ram_rdata.key;
    assign cmp_b      = (state_reg == ST_UP_CMP) ? ram_rdata.key :
                        ((state_reg == ST_DN_R) ? elem_reg.key : best_reg.key);
    assign key_gt     = (cmp_a > cmp_b);
    assign take_right = rv_reg && key_gt;

    // Sequencer: the moving entry is held in elem_reg and written once its slot is found.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        elem_next     = elem_reg;
        best_next     = best_reg;
        best_sel_next = best_sel_reg;
        rv_next       = rv_reg;
        status_next   = status_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = elem_reg;
        ram_re        = 1'b0;
        ram_raddr     = pos_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    status_next = STAT_OK;
                    res_next    = '0;
                    if (s_axis_tuser[0] == CMD_INSERT)
                    begin
                        if (count_reg < CNT_W'(DEPTH))
                        begin
                            pos_next   = IDX_W'(count_reg);
                            elem_next  = in_entry;
                            count_next = count_reg + CNT_W'(1);
                            state_next = ST_UP_RD;
                        end
                        else
                        begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end
                    end
                    else
                    begin
                        if (count_reg != '0)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = ST_EX_ROOT;
                        end
                        else
                        begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_DONE;
                        end
                    end
                end
            end

            // Sift up: at the root the entry settles, else fetch the parent.
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                if (key_gt)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end
            end

            // Extract: capture the root, then fetch the last entry.
            ST_EX_ROOT:
            begin
                res_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = IDX_W'(count_reg - CNT_W'(1));
                state_next = ST_EX_LAST;
            end

            ST_EX_LAST:
            begin
                elem_next  = ram_rdata;
                count_next = count_reg - CNT_W'(1);
                pos_next   = '0;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DN_L;
                end
            end

            // Sift down: fetch the left child if it exists.
            ST_DN_L:
            begin
                if (left_idx < count_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = IDX_W'(left_idx);
                    state_next = ST_DN_R;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end
            end

            // Keep the left child if strictly larger; fetch the right child if it exists.
            ST_DN_R:
            begin
                best_sel_next = key_gt;
                best_next     = key_gt ? ram_rdata : elem_reg;
                rv_next       = (right_idx < count_ext);
                ram_re        = (right_idx < count_ext);
                ram_raddr     = IDX_W'(right_idx);
                state_next    = ST_DN_C;
            end

            // Move the larger child up into the hole, or settle the entry.
            ST_DN_C:
            begin
                ram_we = 1'b1;
                if (take_right)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = IDX_W'(right_idx);
                    state_next = ST_DN_L;
                end
                else if (best_sel_reg)
                begin
                    ram_wdata  = best_reg;
                    pos_next   = IDX_W'(left_idx);
                    state_next = ST_DN_L;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid tracks the result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        elem_reg     <= elem_next;
        best_reg     <= best_next;
        best_sel_reg <= best_sel_next;
        rv_reg       <= rv_next;
        status_reg   <= status_next;
        res_reg      <= res_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_entry_reg  <= res_reg;
            out_fill_reg   <= FILL_W'(count_reg);
        end
    end

    // Result beat.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_fill_reg, out_entry_reg.key, out_entry_reg.id};

    // The entry count never passes the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds heap depth");

    // An accepted beat always starts work.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after accepted beat");

    // While sifting, writes only touch held slots.
    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != ST_IDLE)) |-> (CNT_W'(ram_waddr) < count_reg))
        else $error("heap write beyond held entries");

    // An empty result carries no entry and an empty heap.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STAT_EMPTY))
        |-> ((m_axis_tdata[31:0] == '0) && (m_axis_tdata[36:32] == '0)))
        else $error("empty status with nonzero payload");

endmodule

// ===== sim/tb_max_heap_priority_queue_top.sv =====
// Self-checking testbench for the binary max-heap priority queue top level.
// Depends on mhpq_pkg and the RTL of max_heap_priority_queue_top and its heap RAM.
// A scoreboard class predicts one result beat per command; random idling runs on both sides.
module tb_max_heap_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mhpq_pkg::*;

    localparam int unsigned HEAP_SLOTS = DEPTH_DEFAULT;
    localparam int unsigned DRAIN_CYCLES = 60;

    // One result beat split into its fields.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   out_id;
        logic [KEY_W-1:0]  out_pages;
        logic [FILL_W-1:0] fill_level;
    } heap_result_t;

    // Tracks the heap contents and holds the results still owed by the block.
    class heap_tracker;
        entry_t       slots [HEAP_SLOTS];
        int unsigned  held;
        heap_result_t expected_results [$];
        int unsigned  errors;

        function new();
            held = 0;
            errors = 0;
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            entry_t tmp;
            tmp = slots[a];
            slots[a] = slots[b];
            slots[b] = tmp;
        endfunction

        // Works out the result of one accepted command and updates the heap.
        function void note_command(logic cmd, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
            heap_result_t res;
            int unsigned  pos;
            int unsigned  parent;
            int unsigned  left;
            int unsigned  right;
            int unsigned  best;
            res = '0;
            res.status = STAT_OK;
            if (cmd == CMD_INSERT)
            begin
                if (held < HEAP_SLOTS)
                begin
                    pos = held;
                    slots[pos].id = id;
                    slots[pos].key = key;
                    held = held + 1;
                    // Move up while strictly greater than the parent.
                    while (pos > 0)
                    begin
                        parent = (pos - 1) / 2;
                        if (slots[pos].key <= slots[parent].key)
                            break;
                        swap_slots(pos, parent);
                        pos = parent;
                    end
                end
                else
                begin
                    res.status = STAT_FULL;
                end
            end
            else
            begin
                if (held > 0)
                begin
                    res.out_id = slots[0].id;
                    res.out_pages = slots[0].key;
                    slots[0] = slots[held - 1];
                    held = held - 1;
                    // Move down toward the larger child; the left one wins a tie.
                    pos = 0;
                    while (pos < held)
                    begin
                        left = 2 * pos + 1;
                        right = 2 * pos + 2;
                        best = pos;
                        if (left < held && slots[left].key > slots[best].key)
                            best = left;
                        if (right < held && slots[right].key > slots[best].key)
                            best = right;
                        if (best == pos)
                            break;
                        swap_slots(pos, best);
                        pos = best;
                    end
                end
                else
                begin
                    res.status = STAT_EMPTY;
                end
            end
            res.fill_level = held[FILL_W-1:0];
            expected_results.push_back(res);
        endfunction

        // Compares one accepted result beat with the oldest expectation.
        function void check_result(heap_result_t got);
            heap_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: status %0d id %h pages %h fill %0d",
                         $time, got.status, got.out_id, got.out_pages, got.fill_level);
                errors = errors + 1;
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors = errors + 1;
            end
            if (got.out_id !== want.out_id)
            begin
                $display("%0t: out_id mismatch: expected %h, actual %h",
                         $time, want.out_id, got.out_id);
                errors = errors + 1;
            end
            if (got.out_pages !== want.out_pages)
            begin
                $display("%0t: out_pages mismatch: expected %h, actual %h",
                         $time, want.out_pages, got.out_pages);
                errors = errors + 1;
            end
            if (got.fill_level !== want.fill_level)
            begin
                $display("%0t: fill_level mismatch: expected %0d, actual %0d",
                         $time, want.fill_level, got.fill_level);
                errors = errors + 1;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [15:0] book_id, [31:16] page_count
    logic [0:0]  s_axis_tuser = '0;    // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // [15:0] out_id, [31:16] out_pages, [36:32] fill_level
    logic [1:0]  m_axis_tuser;         // [1:0] status

    // Set by the stimulus for stretches in which neither side idles.
    logic        steady = 1'b0;

    heap_tracker tracker = new();

    max_heap_priority_queue_top #(
        .DEPTH(HEAP_SLOTS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    always #4 clk = ~clk;

    // Hard limit on the run time.
    initial
    begin
        #6_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result beats are checked at the edge where they are accepted.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result({m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                                  m_axis_tdata[36:32]});
    end

    // Output back-pressure: runs of ready, short stalls and a few long ones.
    initial
    begin
        int unsigned pick;
        int unsigned span;
        forever
        begin
            @(negedge clk);
            pick = $urandom_range(0, 99);
            if (steady || pick < 65)
            begin
                m_axis_tready = 1'b1;
                span = $urandom_range(1, 20);
            end
            else
            begin
                m_axis_tready = 1'b0;
                span = (pick < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            end
            repeat (span - 1) @(negedge clk);
        end
    end

    // Lowers valid for a random gap, unless in a steady stretch.
    task automatic idle_source();
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60)
            gap = 0;
        else if (pick < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Offers one command beat and holds it until accepted; starts and ends at a falling edge.
    task automatic issue_command(logic cmd, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
        idle_source();
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tdata = {key, id};
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
            @(negedge clk);
        end
        tracker.note_command(cmd, id, key);
        @(negedge clk);
    endtask

    // Draws a key according to the key mode of the current segment.
    function automatic logic [KEY_W-1:0] draw_key(int unsigned mode);
        if (mode == 1)
            return KEY_W'($urandom_range(0, 3));
        if (mode == 2)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return KEY_W'($urandom);
    endfunction

    // Main stimulus.
    initial
    begin
        int unsigned issued;
        int unsigned seg_len;
        int unsigned insert_pct;
        int unsigned key_mode;
        logic        cmd;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed part: empty extract, key extremes, ties, a full heap and its overflow.
        steady = 1'b1;
        issue_command(CMD_EXTRACT, 16'h0000, 16'h0000);
        issue_command(CMD_INSERT, 16'h0000, 16'h0000);
        issue_command(CMD_INSERT, 16'hFFFF, 16'hFFFF);
        issue_command(CMD_INSERT, 16'h1234, 16'hFFFF);
        issue_command(CMD_INSERT, 16'hA5A5, 16'h8000);
        issue_command(CMD_EXTRACT, 16'hFFFF, 16'hFFFF);
        steady = 1'b0;
        for (int i = 0; i < 13; i++)
            issue_command(CMD_INSERT, 16'h0100 + i[15:0], KEY_W'(16'h0100 * (i % 4)));
        issue_command(CMD_INSERT, 16'h5A5A, 16'hFFFF);
        for (int i = 0; i < 5; i++)
            issue_command(CMD_EXTRACT, 16'h0000, 16'h0000);

        // Random part in segments that lean toward filling or draining the heap.
        issued = 0;
        while (issued < 1900)
        begin
            seg_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0: insert_pct = 15;
                1: insert_pct = 50;
                default: insert_pct = 85;
            endcase
            key_mode = $urandom_range(0, 3);
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < seg_len; n++)
            begin
                cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT;
                issue_command(cmd, ID_W'($urandom), draw_key(key_mode));
            end
            issued = issued + seg_len;
        end
        steady = 1'b0;
        s_axis_tvalid = 1'b0;

        // Wait for every owed result, then watch for stray beats a little longer.
        while (tracker.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0 && tracker.expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ram.sv
rtl/core/max_heap_priority_queue_top.sv
sim/tb_max_heap_priority_queue_top.sv
